/* rtl/wrag_pkg.sv */
// Shared constants and widths for the wyhash random address generator.
`default_nettype none
package wrag_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned PROD_W = 128;
    localparam int unsigned DVD_W  = 32;
    localparam int unsigned LIM_W  = 31;

    localparam logic [WORD_W-1:0] WEYL_INC  = 64'h60be_e2be_e120_fc15;
    localparam logic [WORD_W-1:0] MIX_MUL_A = 64'ha3b1_9535_4a39_b70d;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h1b03_7387_12fa_d5c9;

    localparam logic [LIM_W-1:0]  LIMIT_RESET = 31'd134217728;

endpackage
`default_nettype wire

/* rtl/wrag_rem.sv */
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module wrag_rem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [wrag_pkg::DVD_W-1:0]    i_dividend,
    input  wire logic [wrag_pkg::LIM_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic      [wrag_pkg::LIM_W-1:0]    o_remainder
);

    localparam int unsigned CNT_W = $clog2(wrag_pkg::DVD_W);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [wrag_pkg::DVD_W-1:0]  r_rem, n_rem;
    logic [wrag_pkg::DVD_W-1:0]  r_dvd, n_dvd;
    logic [wrag_pkg::LIM_W-1:0]  r_div, n_div;
    logic [wrag_pkg::DVD_W-1:0]  trial;
    logic [wrag_pkg::DVD_W-1:0]  div_ext;

    // The partial remainder stays below the divisor, so its top bit is free for the shift.
    assign trial   = {r_rem[wrag_pkg::DVD_W-2:0], r_dvd[wrag_pkg::DVD_W-1]};
    assign div_ext = {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[wrag_pkg::DVD_W-2:0], 1'b0};
            n_rem = (trial >= div_ext) ? (trial - div_ext) : trial;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(wrag_pkg::DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem[wrag_pkg::LIM_W-1:0];

endmodule
`default_nettype wire

/* rtl/wyhash_random_address_generator.sv */
// Each item advances a wyhash64 generator and returns its 64-bit word and a bounded
// address. An item goes from acceptance to a valid result through two 64x64
// multiply-fold passes on one shared 32x32 multiplier (four partial products, a drain
// step and one fold each), a restoring remainder by the address limit, a registered
// done flag and the step that takes it, and the load of the output register. The
// input is not ready while an item is in work and is ready again the cycle after
// the result is loaded, so only one item is in work at a time. A zero address limit
// skips the remainder and yields address 0. The finished result sits in an output
// register, so the next item can start while it waits; a second finished result
// holds the block until that register frees. A reseed flag in the item reloads the
// state from the seed register first.
// Registers: seed at 0x0 (64 bits), address limit at 0x8 (31 bits).
`default_nettype none
module wyhash_random_address_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    output logic      [63:0] o_prdata,
    output logic             o_pready,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [0] reseed, [7:1] zero
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [95:0] o_m_axis_tdata    // [30:0] address, [94:31] random_word, [95] 0
);

    localparam logic [3:0] REG_SEED  = 4'h0;
    localparam logic [3:0] REG_LIMIT = 4'h8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_REM  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int unsigned HW = wrag_pkg::HALF_W;
    localparam int unsigned WW = wrag_pkg::WORD_W;

    logic [WW-1:0]                 r_seed;
    logic [wrag_pkg::LIM_W-1:0]    r_limit;
    logic [WW-1:0]                 r_state, n_state;
    logic [2:0]                    r_fsm, n_fsm;
    logic [2:0]                    r_step, n_step;
    logic [1:0]                    r_pp_step;
    logic                          r_pass, n_pass;
    logic [WW-1:0]                 r_opa, n_opa;
    logic [WW-1:0]                 r_pp;
    logic [wrag_pkg::PROD_W-1:0]   r_acc, n_acc;
    logic [wrag_pkg::PROD_W-1:0]   pp_shifted;
    logic [WW-1:0]                 r_word, n_word;
    logic [wrag_pkg::LIM_W-1:0]    r_addr, n_addr;
    logic                          r_out_valid, n_out_valid;
    logic [WW-1:0]                 r_out_word, n_out_word;
    logic [wrag_pkg::LIM_W-1:0]    r_out_addr, n_out_addr;
    logic [WW-1:0]                 opb;
    logic [HW-1:0]                 mul_a, mul_b;
    logic [WW-1:0]                 fold;
    logic [WW-1:0]                 start_state;
    logic                          in_accept, cfg_write;
    logic                          rem_start, rem_done;
    logic [wrag_pkg::LIM_W-1:0]    rem_result;

    assign o_pready  = 1'b1;
    assign cfg_write = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_limit <= wrag_pkg::LIMIT_RESET;
        end else if (cfg_write) begin
            if (i_paddr == REG_SEED) begin
                r_seed <= i_pwdata;
            end
            if (i_paddr == REG_LIMIT) begin
                r_limit <= i_pwdata[wrag_pkg::LIM_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (i_paddr)
            REG_SEED:  o_prdata = r_seed;
            REG_LIMIT: o_prdata = {{(64 - wrag_pkg::LIM_W){1'b0}}, r_limit};
            default:   o_prdata = '0;
        endcase
    end

    assign o_s_axis_tready = (r_fsm == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;
    assign start_state     = i_s_axis_tdata[0] ? r_seed : r_state;

    // Partial product order: lo*lo, hi*lo, lo*hi, hi*hi.
    assign opb   = r_pass ? wrag_pkg::MIX_MUL_B : wrag_pkg::MIX_MUL_A;
    assign mul_a = r_step[0] ? r_opa[WW-1:HW] : r_opa[HW-1:0];
    assign mul_b = r_step[1] ? opb[WW-1:HW]   : opb[HW-1:0];

    always_ff @(posedge i_clk) begin
        r_pp      <= WW'(mul_a) * WW'(mul_b);
        r_pp_step <= r_step[1:0];
    end

    always_comb begin
        unique case (r_pp_step)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd3:    pp_shifted = {r_pp, 64'd0};
            default: pp_shifted = {32'd0, r_pp, 32'd0};
        endcase
    end

    assign fold = r_acc[wrag_pkg::PROD_W-1:WW] ^ r_acc[WW-1:0];

    always_comb begin
        n_state     = r_state;
        n_fsm       = r_fsm;
        n_step      = r_step;
        n_pass      = r_pass;
        n_opa       = r_opa;
        n_acc       = r_acc;
        n_word      = r_word;
        n_addr      = r_addr;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_addr  = r_out_addr;
        rem_start   = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_fsm)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = start_state + wrag_pkg::WEYL_INC;
                    n_opa   = start_state + wrag_pkg::WEYL_INC;
                    n_pass  = 1'b0;
                    n_step  = '0;
                    n_acc   = '0;
                    n_fsm   = ST_MUL;
                end
            end
            ST_MUL: begin
                // Step 0 launches the first product; later steps add the previous one.
                if (r_step != 3'd0) begin
                    n_acc = r_acc + pp_shifted;
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_fsm = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!r_pass) begin
                    n_opa  = fold;
                    n_pass = 1'b1;
                    n_step = '0;
                    n_acc  = '0;
                    n_fsm  = ST_MUL;
                end else begin
                    n_word = fold;
                    if (r_limit == '0) begin
                        n_addr = '0;
                        n_fsm  = ST_DONE;
                    end else begin
                        rem_start = 1'b1;
                        n_fsm     = ST_REM;
                    end
                end
            end
            ST_REM: begin
                if (rem_done) begin
                    n_addr = rem_result;
                    n_fsm  = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_word;
                    n_out_addr  = r_addr;
                    n_fsm       = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_fsm       <= ST_IDLE;
            r_step      <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fsm       <= n_fsm;
            r_step      <= n_step;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
        r_opa      <= n_opa;
        r_acc      <= n_acc;
        r_word     <= n_word;
        r_addr     <= n_addr;
        r_out_word <= n_out_word;
        r_out_addr <= n_out_addr;
    end

    // The remainder unit latches its dividend at the fold edge, before r_word
    // takes the new word, so feed it from n_word.
    wrag_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (rem_start),
        .i_dividend  ({n_word[wrag_pkg::DVD_W-1:3], 3'b000}),
        .i_divisor   (r_limit),
        .o_done      (rem_done),
        .o_remainder (rem_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_word, r_out_addr};

endmodule
`default_nettype wire
